// ----- rtl/tcw_pkg.sv -----
// shared types and constants of the text console cell writer
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 45;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int OP_W    = 3;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR = 8'd32;
  localparam logic [COLOR_W-1:0] BLACK_RGBA = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] WHITE_RGBA = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_CHAR   = 3'd0,
    OP_NEWLINE    = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_HOME       = 3'd3,
    OP_SET_CURSOR = 3'd4,
    OP_SET_COLOR  = 3'd5,
    OP_READ_CELL  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_POST
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
  } cell_t;

endpackage

// ----- rtl/tcw_in_if.sv -----
// request channel of the text console cell writer
`timescale 1ns / 1ps

interface tcw_in_if #(
  parameter int COL_W = 7,
  parameter int ROW_W = 6
);
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::OP_W-1:0]    operation;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::COLOR_W-1:0] color;
  logic                        use_current_color;
  logic [COL_W-1:0]            column;
  logic [ROW_W-1:0]            row;

  modport source (
    output valid, operation, char_code, color, use_current_color, column, row,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, color, use_current_color, column, row,
    output ready
  );
endinterface

// ----- rtl/tcw_out_if.sv -----
// result channel of the text console cell writer
`timescale 1ns / 1ps

interface tcw_out_if #(
  parameter int COL_W = 7,
  parameter int ROW_W = 6,
  parameter int LIN_W = 12
);
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CHAR_W-1:0]  cell_char;
  logic [tcw_pkg::COLOR_W-1:0] cell_color;
  logic [COL_W-1:0]            cursor_col;
  logic [ROW_W-1:0]            cursor_row;
  logic [LIN_W-1:0]            cursor_linear;
  logic [tcw_pkg::COLOR_W-1:0] active_color;

  modport source (
    output valid, cell_char, cell_color, cursor_col, cursor_row, cursor_linear,
           active_color,
    input  ready
  );
  modport sink (
    input  valid, cell_char, cell_color, cursor_col, cursor_row, cursor_linear,
           active_color,
    output ready
  );
endinterface

// ----- rtl/tcw_cell_ram.sv -----
// single-port cell memory with registered read data
`timescale 1ns / 1ps

module tcw_cell_ram #(
  parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   addr,
  input  tcw_pkg::cell_t      wcell,
  output tcw_pkg::cell_t      rcell
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wcell;
    end
    rcell <= mem[addr];
  end

endmodule

// ----- rtl/tcw_ctrl.sv -----
// sequencer: cursor state, ring row mapping, scroll and clear sweeps, result register
`timescale 1ns / 1ps

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  logic               clk,
  input  logic               rst,
  tcw_in_if.sink             cmd,
  tcw_out_if.source          rsp,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_addr,
  output tcw_pkg::cell_t     ram_wcell,
  input  tcw_pkg::cell_t     ram_rcell
);

  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(ROWS);
  localparam int LIN_W = $clog2(CELLS + 1);

  tcw_pkg::state_t state, state_next;
  tcw_pkg::op_t    op;

  logic [ADDR_W-1:0]           cnt, cnt_next;
  logic [ROW_W-1:0]            top, top_next;
  logic [COL_W-1:0]            cur_col, col_next;
  logic [ROW_W-1:0]            cur_row, row_next;
  logic [tcw_pkg::COLOR_W-1:0] pen, pen_next;
  logic [tcw_pkg::CHAR_W-1:0]  rd_char, rd_char_next;
  logic [tcw_pkg::COLOR_W-1:0] rd_color, rd_color_next;

  logic [tcw_pkg::CHAR_W-1:0]  q_char;
  logic [tcw_pkg::COLOR_W-1:0] q_color;
  logic                        q_use;
  logic [COL_W-1:0]            q_x;
  logic [ROW_W-1:0]            q_y;

  logic                        rsp_valid;
  logic [tcw_pkg::CHAR_W-1:0]  rsp_char;
  logic [tcw_pkg::COLOR_W-1:0] rsp_color;
  logic [COL_W-1:0]            rsp_col;
  logic [ROW_W-1:0]            rsp_row;
  logic [LIN_W-1:0]            rsp_lin;
  logic [tcw_pkg::COLOR_W-1:0] rsp_pen;

  logic                        accept;
  logic                        done;
  logic                        rsp_free;
  logic                        rsp_load;

  logic                        wrap;
  logic [ROW_W:0]              row_inc;
  logic [ROW_W:0]              row1_w;
  logic [ROW_W-1:0]            row1;
  logic [COL_W-1:0]            col1;
  logic                        put_scroll;
  logic                        nl_scroll;
  logic [COL_W-1:0]            rx;
  logic [ROW_W-1:0]            ry;
  logic [tcw_pkg::COLOR_W-1:0] put_color;
  logic [ROW_W-1:0]            map_row;
  logic [COL_W-1:0]            map_col;
  logic [ROW_W:0]              ring_sum;
  logic [ROW_W-1:0]            phys_row;
  logic [LIN_W-1:0]            phys_lin;
  logic [ADDR_W-1:0]           phys_addr;

  assign cmd.ready = (state == tcw_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;

  // put_char wraps a pending column first, then may need a scroll
  assign wrap       = (cur_col >= COL_W'(COLUMNS));
  assign row_inc    = {1'b0, cur_row} + (ROW_W+1)'(1);
  assign row1_w     = wrap ? row_inc : {1'b0, cur_row};
  assign row1       = row1_w[ROW_W-1:0];
  assign col1       = wrap ? '0 : cur_col;
  assign put_scroll = (row1_w > (ROW_W+1)'(ROWS - 1));
  assign nl_scroll  = (row_inc > (ROW_W+1)'(ROWS - 1));
  assign put_color  = q_use ? pen : q_color;

  assign rx = (q_x > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : q_x;
  assign ry = (q_y > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : q_y;

  // rows live in a ring: logical row 0 sits at physical row top
  always_comb begin
    if (state == tcw_pkg::ST_SCROLL) begin
      map_row = '0;
      map_col = cnt[COL_W-1:0];
    end else if (op == tcw_pkg::OP_READ_CELL) begin
      map_row = ry;
      map_col = rx;
    end else begin
      map_row = row1;
      map_col = col1;
    end
  end

  assign ring_sum  = {1'b0, top} + {1'b0, map_row};
  assign phys_row  = (ring_sum >= (ROW_W+1)'(ROWS)) ?
                     ROW_W'(ring_sum - (ROW_W+1)'(ROWS)) : ring_sum[ROW_W-1:0];
  assign phys_lin  = LIN_W'(phys_row) * LIN_W'(COLUMNS) + LIN_W'(map_col);
  assign phys_addr = phys_lin[ADDR_W-1:0];

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    top_next      = top;
    col_next      = cur_col;
    row_next      = cur_row;
    pen_next      = pen;
    rd_char_next  = rd_char;
    rd_color_next = rd_color;
    ram_we        = 1'b0;
    ram_addr      = phys_addr;
    ram_wcell     = '0;
    done          = 1'b0;

    case (state)
      tcw_pkg::ST_INIT: begin
        ram_we   = 1'b1;
        ram_addr = cnt;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        rd_char_next  = '0;
        rd_color_next = '0;
        case (op)
          tcw_pkg::OP_PUT_CHAR: begin
            pen_next = put_color;
            if (put_scroll) begin
              // scroll first, then this state runs again to write the cell
              col_next   = '0;
              row_next   = ROW_W'(ROWS - 1);
              cnt_next   = '0;
              state_next = tcw_pkg::ST_SCROLL;
            end else begin
              ram_we    = 1'b1;
              ram_wcell = '{char_code: q_char, color: put_color};
              col_next  = col1 + COL_W'(1);
              row_next  = row1;
              done      = 1'b1;
            end
          end
          tcw_pkg::OP_NEWLINE: begin
            col_next = '0;
            if (nl_scroll) begin
              cnt_next   = '0;
              state_next = tcw_pkg::ST_SCROLL;
            end else begin
              row_next = row_inc[ROW_W-1:0];
              done     = 1'b1;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            cnt_next   = '0;
            top_next   = '0;
            col_next   = '0;
            row_next   = '0;
            pen_next   = tcw_pkg::BLACK_RGBA;
            state_next = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::OP_HOME: begin
            col_next = '0;
            row_next = '0;
            done     = 1'b1;
          end
          tcw_pkg::OP_SET_CURSOR: begin
            col_next = (q_x > COL_W'(COLUMNS)) ? COL_W'(COLUMNS) : q_x;
            row_next = ry;
            done     = 1'b1;
          end
          tcw_pkg::OP_SET_COLOR: begin
            pen_next = q_color;
            done     = 1'b1;
          end
          tcw_pkg::OP_READ_CELL: begin
            state_next = tcw_pkg::ST_READ;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        // zero the old top row, which becomes the new bottom row
        ram_we   = 1'b1;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(COLUMNS - 1)) begin
          cnt_next = '0;
          top_next = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
          if (op == tcw_pkg::OP_PUT_CHAR) begin
            state_next = tcw_pkg::ST_EXEC;
          end else begin
            done = 1'b1;
          end
        end
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt;
        ram_wcell = '{char_code: tcw_pkg::BLANK_CHAR, color: tcw_pkg::BLACK_RGBA};
        cnt_next  = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(CELLS - 1)) begin
          cnt_next = '0;
          done     = 1'b1;
        end
      end
      tcw_pkg::ST_READ: begin
        rd_char_next  = ram_rcell.char_code;
        rd_color_next = ram_rcell.color;
        done          = 1'b1;
      end
      tcw_pkg::ST_POST: begin
        if (rsp_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase

    if (done) begin
      state_next = rsp_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_POST;
    end
  end

  // next values equal the held ones while waiting in post
  assign rsp_load = (done || (state == tcw_pkg::ST_POST)) && rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      cnt       <= '0;
      top       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      pen       <= tcw_pkg::WHITE_RGBA;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      top     <= top_next;
      cur_col <= col_next;
      cur_row <= row_next;
      pen     <= pen_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_char  <= rd_char_next;
    rd_color <= rd_color_next;
    if (accept) begin
      op      <= tcw_pkg::op_t'(cmd.operation);
      q_char  <= cmd.char_code;
      q_color <= cmd.color;
      q_use   <= cmd.use_current_color;
      q_x     <= cmd.column;
      q_y     <= cmd.row;
    end
    if (rsp_load) begin
      rsp_char  <= rd_char_next;
      rsp_color <= rd_color_next;
      rsp_col   <= col_next;
      rsp_row   <= row_next;
      rsp_lin   <= LIN_W'(row_next) * LIN_W'(COLUMNS) + LIN_W'(col_next);
      rsp_pen   <= pen_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.cell_char     = rsp_char;
  assign rsp.cell_color    = rsp_color;
  assign rsp.cursor_col    = rsp_col;
  assign rsp.cursor_row    = rsp_row;
  assign rsp.cursor_linear = rsp_lin;
  assign rsp.active_color  = rsp_pen;

endmodule

// ----- rtl/text_console_cell_writer.sv -----
// Text console of COLUMNS x ROWS character cells (80 x 45 by default), each cell an 8-bit
// character and a 32-bit RGBA color, held in one single-port memory with a registered read.
// Rows sit in a ring, so a scroll rewrites only the new bottom row. One request is worked on
// at a time and gives one result. After reset the memory is zeroed by a pass over all
// COLUMNS*ROWS (3600) cells, during which no request is taken. read_cell does one memory
// read; newline and put_char with scroll make one memory write per cell of the cleared row,
// and clear makes one memory write per cell. A new request is taken while the previous
// result still waits to be taken.
`timescale 1ns / 1ps

module text_console_cell_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcw_in_if.sink     cmd,
  tcw_out_if.source  rsp
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  tcw_pkg::cell_t    ram_wcell;
  tcw_pkg::cell_t    ram_rcell;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wcell (ram_wcell),
    .ram_rcell (ram_rcell)
  );

  tcw_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wcell (ram_wcell),
    .rcell (ram_rcell)
  );

endmodule

// ----- bench/text_console_cell_writer_test.sv -----
// testbench of the text console cell writer: directed and random requests checked against a cell-level predictor
`timescale 1ns / 1ps

module text_console_cell_writer_test;

  localparam int COLS    = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS    = tcw_pkg::ROWS_DEF;
  localparam int CELLS   = COLS * ROWS;
  localparam int OP_W    = tcw_pkg::OP_W;
  localparam int CHAR_W  = tcw_pkg::CHAR_W;
  localparam int COLOR_W = tcw_pkg::COLOR_W;
  localparam int COL_W = 7;
  localparam int ROW_W = 6;
  localparam int LIN_W = 12;
  localparam int DIRECTED_REQS = 25;
  localparam int RANDOM_REQS   = 950;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] rgba;
    logic               use_pen;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    bit                 drain;
  } request_t;

  typedef struct {
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [LIN_W-1:0]   cursor_linear;
    logic [COLOR_W-1:0] active_color;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcw_in_if  #(.COL_W(COL_W), .ROW_W(ROW_W)) cmd_if ();
  tcw_out_if #(.COL_W(COL_W), .ROW_W(ROW_W), .LIN_W(LIN_W)) rsp_if ();

  text_console_cell_writer i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always #1 clk = ~clk;

  // console copy kept by the predictor
  logic [CHAR_W-1:0]  char_mem  [CELLS];
  logic [COLOR_W-1:0] color_mem [CELLS];
  int                 cur_x;
  int                 cur_y;
  logic [COLOR_W-1:0] pen_rgba;
  int                 op_seen [8];
  int                 scroll_seen;

  request_t pending_q [$];
  status_t  status_q [$];
  bit       drain_next;
  int       total_reqs = 1 << 30;
  int       n_issued;
  int       n_done;
  int       errors;
  int       gap_left;
  int       stall_left;
  int       hold_left;
  bit       hold_done;
  logic     quiet;

  assign quiet = (n_issued + 100 >= total_reqs);

  function automatic void scroll_up();
    for (int k = 0; k < CELLS - COLS; k++) begin
      char_mem[k]  = char_mem[k + COLS];
      color_mem[k] = color_mem[k + COLS];
    end
    for (int k = CELLS - COLS; k < CELLS; k++) begin
      char_mem[k]  = '0;
      color_mem[k] = '0;
    end
    scroll_seen++;
  endfunction

  function automatic status_t console_step(request_t r);
    status_t            s;
    logic [COLOR_W-1:0] c;
    int                 idx;
    int                 rx;
    int                 ry;
    s.cell_char  = '0;
    s.cell_color = '0;
    op_seen[r.op]++;
    case (r.op)
      tcw_pkg::OP_PUT_CHAR: begin
        c = r.use_pen ? pen_rgba : r.rgba;
        pen_rgba = c;
        // pending wrap resolves before the write
        if (cur_x >= COLS) begin
          cur_x = 0;
          cur_y++;
        end
        if (cur_y > ROWS - 1) begin
          scroll_up();
          cur_y = ROWS - 1;
        end
        idx = cur_y * COLS + cur_x;
        char_mem[idx]  = r.ch;
        color_mem[idx] = c;
        cur_x++;
      end
      tcw_pkg::OP_NEWLINE: begin
        cur_x = 0;
        cur_y++;
        if (cur_y > ROWS - 1) begin
          scroll_up();
          cur_y = ROWS - 1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (int k = 0; k < CELLS; k++) begin
          char_mem[k]  = tcw_pkg::BLANK_CHAR;
          color_mem[k] = tcw_pkg::BLACK_RGBA;
        end
        pen_rgba = tcw_pkg::BLACK_RGBA;
        cur_x = 0;
        cur_y = 0;
      end
      tcw_pkg::OP_HOME: begin
        cur_x = 0;
        cur_y = 0;
      end
      tcw_pkg::OP_SET_CURSOR: begin
        cur_x = (r.col > COLS) ? COLS : int'(r.col);
        cur_y = (r.row > ROWS - 1) ? ROWS - 1 : int'(r.row);
      end
      tcw_pkg::OP_SET_COLOR: begin
        pen_rgba = r.rgba;
      end
      tcw_pkg::OP_READ_CELL: begin
        rx = (r.col > COLS - 1) ? COLS - 1 : int'(r.col);
        ry = (r.row > ROWS - 1) ? ROWS - 1 : int'(r.row);
        s.cell_char  = char_mem[ry * COLS + rx];
        s.cell_color = color_mem[ry * COLS + rx];
      end
      default: begin
      end
    endcase
    s.cursor_col    = COL_W'(cur_x);
    s.cursor_row    = ROW_W'(cur_y);
    s.cursor_linear = LIN_W'(cur_y * COLS + cur_x);
    s.active_color  = pen_rgba;
    return s;
  endfunction

  task automatic push_req(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                          logic [COLOR_W-1:0] rgba, logic use_pen,
                          logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    request_t r;
    r.op      = op;
    r.ch      = ch;
    r.rgba    = rgba;
    r.use_pen = use_pen;
    r.col     = col;
    r.row     = row;
    r.drain   = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic took;
    logic busy;
    if (rst) begin
      cmd_if.valid <= 1'b0;
      gap_left     <= 0;
      n_issued     <= 0;
      for (int k = 0; k < CELLS; k++) begin
        char_mem[k]  = '0;
        color_mem[k] = '0;
      end
      cur_x    = 0;
      cur_y    = 0;
      pen_rgba = tcw_pkg::WHITE_RGBA;
    end else begin
      took = cmd_if.valid && cmd_if.ready;
      busy = cmd_if.valid && !took;
      if (took) begin
        status_q.push_back(console_step(pending_q.pop_front()));
        n_issued <= n_issued + 1;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          cmd_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left     <= $urandom_range(0, 9);
          cmd_if.valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          cmd_if.valid <= 1'b0;
        end else if (pending_q[0].drain && (took || n_issued != n_done)) begin
          // hold this request until every result is back
          cmd_if.valid <= 1'b0;
        end else begin
          cmd_if.valid             <= 1'b1;
          cmd_if.operation         <= pending_q[0].op;
          cmd_if.char_code         <= pending_q[0].ch;
          cmd_if.color             <= pending_q[0].rgba;
          cmd_if.use_current_color <= pending_q[0].use_pen;
          cmd_if.column            <= pending_q[0].col;
          cmd_if.row               <= pending_q[0].row;
        end
      end
    end
  end

  // long result hold-off once the run is under way
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_issued >= 200) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      n_done       <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: result with none expected, cursor %0d,%0d", $time,
                   rsp_if.cursor_col, rsp_if.cursor_row);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("cell_char", 32'(want.cell_char), 32'(rsp_if.cell_char));
          check_field("cell_color", want.cell_color, rsp_if.cell_color);
          check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_if.cursor_col));
          check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_if.cursor_row));
          check_field("cursor_linear", 32'(want.cursor_linear),
                      32'(rsp_if.cursor_linear));
          check_field("active_color", want.active_color, rsp_if.active_color);
          n_done <= n_done + 1;
        end
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #1_500_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int kind;
    int base_row;
    int len;
    int rr;
    cmd_if.valid             = 1'b0;
    cmd_if.operation         = '0;
    cmd_if.char_code         = '0;
    cmd_if.color             = '0;
    cmd_if.use_current_color = 1'b0;
    cmd_if.column            = '0;
    cmd_if.row               = '0;
    rsp_if.ready             = 1'b0;

    // directed part
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_PUT_CHAR, 8'h48, 32'h1122_3344, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_PUT_CHAR, 8'h69, $urandom, 1'b1, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd1, 6'd0);
    push_req(tcw_pkg::OP_SET_COLOR, 8'h00, 32'hA5C3_5A3C, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_PUT_CHAR, 8'hFF, 32'h0, 1'b1, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_SET_CURSOR, 8'h00, 32'h0, 1'b0, 7'd127, 6'd63);
    // wrap pending on the bottom row: scroll then write
    push_req(tcw_pkg::OP_PUT_CHAR, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd127, 6'd63);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd0, 6'd44);
    push_req(tcw_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd0, 6'd43);
    push_req(tcw_pkg::OP_HOME, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_SET_CURSOR, 8'h00, 32'h0, 1'b0, 7'd79, 6'd0);
    push_req(tcw_pkg::OP_PUT_CHAR, 8'h5A, 32'hFFFF_FFFF, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_PUT_CHAR, 8'h7A, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd79, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd0, 6'd1);
    push_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, 7'd127, 6'd63);
    push_req(tcw_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_CLEAR, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd5, 6'd5);
    push_req(tcw_pkg::OP_SET_CURSOR, 8'h00, 32'h0, 1'b0, 7'd80, 6'd44);
    push_req(tcw_pkg::OP_NEWLINE, 8'h00, 32'h0, 1'b0, 7'd0, 6'd0);
    push_req(tcw_pkg::OP_READ_CELL, 8'h00, 32'h0, 1'b0, 7'd79, 6'd44);
    drain_next = 1'b1;

    // random part, mostly strings written near the bottom so scrolls happen
    while (pending_q.size() < DIRECTED_REQS + RANDOM_REQS) begin
      if (pending_q.size() % 300 == 0)
        drain_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        base_row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1)
                                               : ROWS - 1 - $urandom_range(0, 1);
        push_req(tcw_pkg::OP_SET_CURSOR, CHAR_W'($urandom), $urandom,
                 1'($urandom_range(0, 1)), COL_W'($urandom_range(0, COLS)),
                 ROW_W'(base_row));
        len = $urandom_range(1, 24);
        repeat (len) begin
          if ($urandom_range(0, 11) == 0)
            push_req(tcw_pkg::OP_NEWLINE, CHAR_W'($urandom), $urandom,
                     1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
          else
            push_req(tcw_pkg::OP_PUT_CHAR, CHAR_W'($urandom), $urandom,
                     1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
        end
        // read back around the written row, which may have scrolled up
        repeat ($urandom_range(1, 3)) begin
          rr = base_row - $urandom_range(0, 2);
          if (rr < 0)
            rr = 0;
          push_req(tcw_pkg::OP_READ_CELL, CHAR_W'($urandom), $urandom,
                   1'($urandom_range(0, 1)), COL_W'($urandom_range(0, COLS - 1)),
                   ROW_W'(rr));
        end
      end else if (kind < 60) begin
        push_req(tcw_pkg::OP_READ_CELL, CHAR_W'($urandom), $urandom,
                 1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 4))
          push_req(tcw_pkg::OP_NEWLINE, CHAR_W'($urandom), $urandom,
                   1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
      end else if (kind < 80) begin
        push_req($urandom_range(0, 1) ? tcw_pkg::OP_SET_COLOR : tcw_pkg::OP_HOME,
                 CHAR_W'($urandom), $urandom, 1'($urandom_range(0, 1)),
                 COL_W'($urandom), ROW_W'($urandom));
      end else if (kind < 99) begin
        push_req(OP_W'($urandom_range(0, 7)), CHAR_W'($urandom), $urandom,
                 1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
      end else begin
        push_req(tcw_pkg::OP_CLEAR, CHAR_W'($urandom), $urandom,
                 1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom));
      end
    end
    total_reqs = pending_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || n_done != n_issued)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d put_char, %0d newline, %0d read_cell, %0d clear",
             n_issued, op_seen[tcw_pkg::OP_PUT_CHAR], op_seen[tcw_pkg::OP_NEWLINE],
             op_seen[tcw_pkg::OP_READ_CELL], op_seen[tcw_pkg::OP_CLEAR]);
    $display("%0d scrolls, %0d unused codes, one long result hold-off, drained pauses",
             scroll_seen, op_seen[OP_UNUSED]);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
